// File: design/srm_pkg.sv
// Shared types, widths and constants for the step response metrics block.
package srm_pkg;

    // Field widths
    localparam int POSITION_BITS = 21;
    localparam int TIME_BITS     = 16;
    localparam int SCORE_BITS    = 29;
    localparam int CFG_BITS      = 16;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Stream payload layout, lowest field first
    localparam int IN_FIELDS_W  = 2 * POSITION_BITS + TIME_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_POS_LSB   = 0;
    localparam int IN_TGT_LSB   = IN_POS_LSB + POSITION_BITS;
    localparam int IN_TIME_LSB  = IN_TGT_LSB + POSITION_BITS;

    localparam int OUT_FIELDS_W = 3 * POSITION_BITS + 2 * TIME_BITS + SCORE_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PEAK_LSB  = 0;
    localparam int OUT_RISE_LSB  = OUT_PEAK_LSB + POSITION_BITS;
    localparam int OUT_SETTL_LSB = OUT_RISE_LSB + TIME_BITS;
    localparam int OUT_FERR_LSB  = OUT_SETTL_LSB + TIME_BITS;
    localparam int OUT_FPOS_LSB  = OUT_FERR_LSB + POSITION_BITS;
    localparam int OUT_SCORE_LSB = OUT_FPOS_LSB + POSITION_BITS;

    // Comparison widths between config registers and field values
    localparam int TCMP_W = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam int ECMP_W = (POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS;

    // Ninety percent test operands: 10 * (POSITION_BITS+1) signed
    localparam int RISE_W = POSITION_BITS + 5;

    // Score accumulator wide enough for every term plus carries
    localparam int SUM_A_W = (POSITION_BITS + 8 > TIME_BITS + 2) ?
                             POSITION_BITS + 8 : TIME_BITS + 2;
    localparam int SUM_W   = ((SUM_A_W > SCORE_BITS) ? SUM_A_W : SCORE_BITS) + 1;

    // Moves of this size or less skip overshoot tracking
    localparam int MOVE_THRESHOLD = 50;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0] RST_SETTLE_TOL = CFG_BITS'(50);
    localparam logic [CFG_BITS-1:0] RST_TIMEOUT    = CFG_BITS'(5000);
    localparam logic [CFG_BITS-1:0] RST_WINDOW     = CFG_BITS'(500);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TRACK   = 2'd1,
        PH_CONFIRM = 2'd2,
        PH_FINAL   = 2'd3
    } t_phase;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SETTLE_TOL = 2'd0,
        REG_TIMEOUT    = 2'd1,
        REG_WINDOW     = 2'd2
    } t_reg_idx;

    // Saturated score from the latched metrics
    function automatic logic [SCORE_BITS-1:0] calc_score(
        input logic [POSITION_BITS-1:0] peak,
        input logic [TIME_BITS-1:0]     settle,
        input logic [POSITION_BITS-1:0] ferr,
        input logic [TIME_BITS-1:0]     rise
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(peak) * SUM_W'(100)
            + (SUM_W'(settle) << 1)
            + SUM_W'(ferr) * SUM_W'(50)
            + SUM_W'(rise >> 1);
        if (sum > SUM_W'({SCORE_BITS{1'b1}})) begin
            return {SCORE_BITS{1'b1}};
        end
        return sum[SCORE_BITS-1:0];
    endfunction

endpackage

// File: design/step_response_metrics_top.sv
// Top level of the step response analyzer: stream in, metrics out, APB config.
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: position, target, elapsed
//                                                   tuser: opcode
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: metrics and score
//                                                   tuser: measurement_valid
//  apb       in   i_psel/i_penable/o_pready      3 registers of 16 bits at 0x0/0x4/0x8
//
// One item per cycle unless a final reading waits for room in the output register; an item
// passes through the input register and its result, if any, is registered in the output register.
// The phase and metric registers feed back to themselves through the update logic.
// Reset is synchronous; it clears control state and loads the register defaults.
// A stalled output holds only a final-reading item; other items keep flowing while none is held.
module step_response_metrics_top
    import srm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [20:0] position, [41:21] target_position, [57:42] elapsed_ms, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  logic                  i_s_axis_tuser,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [20:0] max_overshoot, [36:21] rise_ms, [52:37] settle_ms,
    // [73:53] final_error, [94:74] last_position, [123:95] score, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] measurement_valid
    output logic                  o_m_axis_tuser,
    // Configuration port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam logic signed [POSITION_BITS:0] MOVE_MIN = (POSITION_BITS+1)'(MOVE_THRESHOLD);
    localparam logic signed [RISE_W-1:0]      K_TEN    = RISE_W'(10);
    localparam logic signed [RISE_W-1:0]      K_NINE   = RISE_W'(9);
    localparam logic [TIME_BITS-1:0]          TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration registers
    logic [CFG_BITS-1:0] r_settle_tol;
    logic [CFG_BITS-1:0] r_timeout;
    logic [CFG_BITS-1:0] r_window;
    t_reg_idx            s_reg_idx;
    logic                s_cfg_wr;

    // Input register
    logic                            r_in_valid;
    t_opcode                         r_in_op;
    logic signed [POSITION_BITS-1:0] r_in_pos;
    logic signed [POSITION_BITS-1:0] r_in_tgt;
    logic [TIME_BITS-1:0]            r_in_time;

    // Measurement state
    t_phase                          r_phase, n_phase;
    logic signed [POSITION_BITS-1:0] r_target, n_target;
    logic signed [POSITION_BITS-1:0] r_initial, n_initial;
    logic signed [POSITION_BITS:0]   r_delta, n_delta;
    logic [POSITION_BITS-1:0]        r_peak, n_peak;
    logic [TIME_BITS-1:0]            r_rise, n_rise;
    logic                            r_rise_hit, n_rise_hit;
    logic [TIME_BITS-1:0]            r_settle, n_settle;
    logic                            r_good, n_good;

    // Result register
    logic                            r_out_valid;
    logic [POSITION_BITS-1:0]        r_out_peak;
    logic [TIME_BITS-1:0]            r_out_rise;
    logic [TIME_BITS-1:0]            r_out_settle;
    logic [POSITION_BITS-1:0]        r_out_ferr;
    logic signed [POSITION_BITS-1:0] r_out_fpos;
    logic [SCORE_BITS-1:0]           r_out_score;
    logic                            r_out_meas;

    // Datapath terms
    logic                            s_produce;
    logic                            s_advance;
    logic signed [POSITION_BITS:0]   s_diff;
    logic [POSITION_BITS:0]          s_abs;
    logic [POSITION_BITS-1:0]        s_err;
    logic                            s_in_tol;
    logic                            s_timed_out;
    logic                            s_big_move;
    logic                            s_overshoot;
    logic signed [POSITION_BITS:0]   s_travel;
    logic signed [RISE_W-1:0]        s_lhs;
    logic signed [RISE_W-1:0]        s_rhs;
    logic                            s_rise_now;
    logic [TIME_BITS-1:0]            s_waited;
    logic                            s_wait_done;
    logic [SCORE_BITS-1:0]           s_score;

    // APB: always ready, write in the access phase
    assign o_pready  = 1'b1;
    assign s_reg_idx = t_reg_idx'(i_paddr[3:2]);
    assign s_cfg_wr  = i_psel && i_penable && i_pwrite;

    always_comb begin
        unique case (s_reg_idx)
            REG_SETTLE_TOL: o_prdata = APB_DATA_W'(r_settle_tol);
            REG_TIMEOUT:    o_prdata = APB_DATA_W'(r_timeout);
            REG_WINDOW:     o_prdata = APB_DATA_W'(r_window);
            default:        o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_tol <= RST_SETTLE_TOL;
            r_timeout    <= RST_TIMEOUT;
            r_window     <= RST_WINDOW;
        end else if (s_cfg_wr) begin
            unique case (s_reg_idx)
                REG_SETTLE_TOL: r_settle_tol <= i_pwdata[CFG_BITS-1:0];
                REG_TIMEOUT:    r_timeout    <= i_pwdata[CFG_BITS-1:0];
                REG_WINDOW:     r_window     <= i_pwdata[CFG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Flow control: only a final reading needs room in the result register
    assign s_produce       = r_in_valid && (r_in_op == OP_SAMPLE) && (r_phase == PH_FINAL);
    assign s_advance       = r_in_valid && (!s_produce || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || s_advance;

    // Capture input transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op   <= t_opcode'(i_s_axis_tuser);
            r_in_pos  <= i_s_axis_tdata[IN_POS_LSB +: POSITION_BITS];
            r_in_tgt  <= i_s_axis_tdata[IN_TGT_LSB +: POSITION_BITS];
            r_in_time <= i_s_axis_tdata[IN_TIME_LSB +: TIME_BITS];
        end
    end

    // Error to target and the tests on the current sample
    assign s_diff      = (POSITION_BITS+1)'(r_target) - (POSITION_BITS+1)'(r_in_pos);
    assign s_abs       = s_diff[POSITION_BITS] ? (POSITION_BITS+1)'(-s_diff)
                                               : (POSITION_BITS+1)'(s_diff);
    assign s_err       = s_abs[POSITION_BITS-1:0];
    assign s_in_tol    = ECMP_W'(s_err) < ECMP_W'(r_settle_tol);
    assign s_timed_out = TCMP_W'(r_in_time) >= TCMP_W'(r_timeout);
    assign s_big_move  = (r_delta > MOVE_MIN) || (r_delta < -MOVE_MIN);
    assign s_overshoot = s_big_move &&
                         (((r_delta > 0) && (r_in_pos > r_target)) ||
                          ((r_delta < 0) && (r_in_pos < r_target)));

    // Ninety percent of the move, exact: 10*(pos-initial) against 9*delta
    assign s_travel   = (POSITION_BITS+1)'(r_in_pos) - (POSITION_BITS+1)'(r_initial);
    assign s_lhs      = RISE_W'(s_travel) * K_TEN;
    assign s_rhs      = RISE_W'(r_delta) * K_NINE;
    assign s_rise_now = ((r_delta > 0) && (s_lhs >= s_rhs)) ||
                        ((r_delta < 0) && (s_lhs <= s_rhs));

    // Confirmation window
    assign s_waited    = (r_in_time >= r_settle) ? r_in_time - r_settle : '0;
    assign s_wait_done = (TCMP_W'(s_waited) >= TCMP_W'(r_window)) || (r_in_time == TIME_MAX);

    assign s_score = calc_score(r_peak, r_settle, s_err, r_rise);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_op == OP_START) begin
            n_phase = PH_TRACK;
        end else begin
            unique case (r_phase)
                PH_IDLE:    n_phase = PH_IDLE;
                PH_TRACK: begin
                    if (s_timed_out) begin
                        n_phase = PH_FINAL;
                    end else if (s_in_tol) begin
                        n_phase = PH_CONFIRM;
                    end
                end
                PH_CONFIRM: begin
                    if (s_wait_done) begin
                        n_phase = s_in_tol ? PH_FINAL : PH_TRACK;
                    end
                end
                PH_FINAL:   n_phase = PH_IDLE;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    // Metric updates
    always_comb begin
        n_target   = r_target;
        n_initial  = r_initial;
        n_delta    = r_delta;
        n_peak     = r_peak;
        n_rise     = r_rise;
        n_rise_hit = r_rise_hit;
        n_settle   = r_settle;
        n_good     = r_good;
        if (r_in_op == OP_START) begin
            n_target   = r_in_tgt;
            n_initial  = r_in_pos;
            n_delta    = (POSITION_BITS+1)'(r_in_tgt) - (POSITION_BITS+1)'(r_in_pos);
            n_peak     = '0;
            n_rise     = '0;
            n_rise_hit = 1'b0;
            n_settle   = '0;
            n_good     = 1'b0;
        end else begin
            case (r_phase)
                PH_TRACK: begin
                    if (s_timed_out) begin
                        n_good = 1'b0;
                    end else begin
                        if (s_overshoot && (s_err > r_peak)) begin
                            n_peak = s_err;
                        end
                        if (!r_rise_hit && s_rise_now) begin
                            n_rise     = r_in_time;
                            n_rise_hit = 1'b1;
                        end
                        if (s_in_tol) begin
                            n_settle = r_in_time;
                        end
                    end
                end
                PH_CONFIRM: begin
                    if (s_wait_done && s_in_tol) begin
                        n_good = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance the measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_target   <= '0;
            r_initial  <= '0;
            r_delta    <= '0;
            r_peak     <= '0;
            r_rise     <= '0;
            r_rise_hit <= 1'b0;
            r_settle   <= '0;
            r_good     <= 1'b0;
        end else if (s_advance) begin
            r_phase    <= n_phase;
            r_target   <= n_target;
            r_initial  <= n_initial;
            r_delta    <= n_delta;
            r_peak     <= n_peak;
            r_rise     <= n_rise;
            r_rise_hit <= n_rise_hit;
            r_settle   <= n_settle;
            r_good     <= n_good;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance && s_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_produce) begin
            r_out_peak   <= r_peak;
            r_out_rise   <= r_rise;
            r_out_settle <= r_settle;
            r_out_ferr   <= s_err;
            r_out_fpos   <= r_in_pos;
            r_out_score  <= s_score;
            r_out_meas   <= r_good && !s_timed_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_meas;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_score, r_out_fpos, r_out_ferr,
                                          r_out_settle, r_out_rise, r_out_peak});

endmodule

// File: design/srm_checker.sv
// Port-level checks for the step response analyzer, bound to the top level.
module srm_checker
    import srm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    logic [SCORE_BITS-1:0] s_expect_score;

    // Recompute the score from the metric fields that travel beside it
    assign s_expect_score = calc_score(o_m_axis_tdata[OUT_PEAK_LSB +: POSITION_BITS],
                                       o_m_axis_tdata[OUT_SETTL_LSB +: TIME_BITS],
                                       o_m_axis_tdata[OUT_FERR_LSB +: POSITION_BITS],
                                       o_m_axis_tdata[OUT_RISE_LSB +: TIME_BITS]);

    // No result comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Score agrees with the reported metrics
    a_score_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_SCORE_LSB +: SCORE_BITS] == s_expect_score))
        else $error("score does not match the reported metrics");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before its transaction");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result payload changed while stalled");

endmodule

bind step_response_metrics_top srm_checker u_srm_checker (.*);
